/* rtl/ipac_pkg.sv */
// ----------------------------------------------------------------------------
// ipac_pkg
// Shared codes, entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ipac_pkg;

  localparam int PREFIX_OCTETS_MAX = 4;
  localparam int ADDR_W          = 32;
  localparam int PREFIX_W        = 3;
  localparam int ENTRY_W         = ADDR_W + PREFIX_W;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic scan_step;  // read next entry, fold in previous compare
    logic finish;     // fold in last compare, load the result
  } ipac_cmd_t;

  typedef struct packed {
    logic list_on;
    logic empty;
    logic scan_last;
    logic out_busy;   // result held and stalled
  } ipac_stat_t;

  // mask of the leading octets; lengths past four cover the whole address
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] octets);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int k = 0; k < PREFIX_OCTETS_MAX; k++) begin
      if (32'(octets) > k) begin
        m[ADDR_W-1-8*k -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/ipac_ram.sv */
// ----------------------------------------------------------------------------
// ipac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/ipac_ctrl.sv */
// ----------------------------------------------------------------------------
// ipac_ctrl
// Sequencer: takes a beat, scans the table for checks on an enabled, non-empty list, then flushes.
// ----------------------------------------------------------------------------
module ipac_ctrl import ipac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  ipac_stat_t stat,
  output ipac_cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FLUSH
  } state_t;

  state_t state;
  logic   take_ok;

  always_comb begin
    take_ok       = (state == IDLE) && !stat.out_busy;
    in_stall      = !take_ok;
    cmd.accept    = in_valid && take_ok;
    cmd.scan_step = (state == SCAN);
    cmd.finish    = (state == FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.accept && operation == OP_CHECK && stat.list_on && !stat.empty) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (stat.scan_last) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/ipac_dp.sv */
// ----------------------------------------------------------------------------
// ipac_dp
// Entry table, fill count, scan index, prefix compare and result register.
// ----------------------------------------------------------------------------
module ipac_dp import ipac_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ipac_cmd_t           cmd,
  output ipac_stat_t          stat,
  input  logic                list_enabled,
  input  logic [1:0]          operation,
  input  logic [ADDR_W-1:0]   address,
  input  logic [PREFIX_W-1:0] prefix_octets,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                permitted,
  output logic                table_full
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [CNT_W-1:0]   entry_count;
  logic [IDX_W-1:0]   scan_idx;
  logic               rd_pending;
  logic               hit;
  logic [ADDR_W-1:0]  chk_addr;

  logic [ENTRY_W-1:0] rd_data;
  logic               full, empty, wr_en, match;
  logic               load, load_perm, load_full;

  assign full  = (entry_count == CNT_W'(MAX_ENTRIES));
  assign empty = (entry_count == '0);
  assign wr_en = cmd.accept && (operation == OP_ADD) && !full;

  ipac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data ({prefix_octets, address}),
    .rd_en   (cmd.scan_step),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  assign match = ((chk_addr ^ rd_data[ADDR_W-1:0])
                  & prefix_mask(rd_data[ENTRY_W-1 -: PREFIX_W])) == '0;

  always_comb begin
    load      = 1'b0;
    load_perm = 1'b0;
    load_full = 1'b0;
    if (cmd.accept) begin
      unique case (operation)
        OP_CLEAR: load = 1'b1;
        OP_ADD: begin
          load      = 1'b1;
          load_full = full;
        end
        OP_CHECK: begin
          if (!list_enabled) begin
            load      = 1'b1;
            load_perm = 1'b1;
          end else if (empty) begin
            load = 1'b1;
          end
        end
        default: load = 1'b1;
      endcase
    end else if (cmd.finish) begin
      load      = 1'b1;
      load_perm = hit || (rd_pending && match);
    end
  end

  always_comb begin
    stat.list_on   = list_enabled;
    stat.empty     = empty;
    stat.scan_last = (CNT_W'(scan_idx) == entry_count - CNT_W'(1));
    stat.out_busy  = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      scan_idx    <= '0;
      rd_pending  <= 1'b0;
      hit         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (operation == OP_CLEAR) begin
          entry_count <= '0;
        end else if (wr_en) begin
          entry_count <= entry_count + CNT_W'(1);
        end
        scan_idx   <= '0;
        rd_pending <= 1'b0;
        hit        <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_idx   <= scan_idx + IDX_W'(1);
        rd_pending <= 1'b1;
        if (rd_pending && match) begin
          hit <= 1'b1;
        end
      end
      if (cmd.finish) begin
        rd_pending <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chk_addr <= address;
    end
    if (load) begin
      permitted  <= load_perm;
      table_full <= load_full;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count past table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(load && out_valid && out_stall))
    else $error("result loaded over a stalled beat");

  a_finish_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> rd_pending && $past(cmd.scan_step))
    else $error("flush without a pending entry read");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> CNT_W'(scan_idx) < entry_count)
    else $error("scan index beyond filled entries");

endmodule

/* rtl/ipv4_prefix_access_check.sv */
// ----------------------------------------------------------------------------
// ipv4_prefix_access_check
// IPv4 access list with whole-octet prefix matching and a 1-bit enable.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Clear, add, unused operations and checks
// with the list disabled or empty need no scan: the result is registered
// at the accepting edge and, unless the output stalls, the next beat can be
// taken the cycle after. A check against an enabled list scans every stored
// entry: the entry table sits in a RAM with one registered read port, so the
// scan reads one entry per cycle and compares it the cycle after, and a flush
// state folds in the last compare. A finished result waits in the output
// register; a new beat is taken once that register is empty or is being
// drained in the same cycle. The list enable register sits at byte address 0
// (paddr[2] low) and reads back.
// ----------------------------------------------------------------------------
module ipv4_prefix_access_check import ipac_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // item input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [ADDR_W-1:0]   address,
  input  logic [PREFIX_W-1:0] prefix_octets,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output logic                permitted,
  output logic                table_full
);

  // register select is the word address bit
  localparam logic REG_LIST_ENABLED = 1'b0;

  logic       list_enabled;
  ipac_cmd_t  cmd;
  ipac_stat_t stat;

  // --- configuration ---------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIST_ENABLED) ? {31'b0, list_enabled} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_enabled <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIST_ENABLED) begin
      list_enabled <= pwdata[0];
    end
  end

  // --- sequencer -------------------------------------------------------------
  ipac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd)
  );

  // --- table, compare and result register ------------------------------------
  ipac_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .list_enabled  (list_enabled),
    .operation     (operation),
    .address       (address),
    .prefix_octets (prefix_octets),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .permitted     (permitted),
    .table_full    (table_full)
  );

endmodule

/* verif/ipv4_prefix_access_check_tb.sv */
// ----------------------------------------------------------------------------
// ipv4_prefix_access_check_tb
// Self-checking bench for the IPv4 prefix access list. A directed table
// covers the corner cases. Random sessions follow: clear, a run of adds,
// then checks mostly aimed at the stored entries, mixed with stray beats.
// Results are compared against an in-bench table model or a typed row's want.
// ----------------------------------------------------------------------------
module ipv4_prefix_access_check_tb import ipac_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACL_DEPTH      = 16;
  localparam int REG_LIST_EN    = 0;            // register index
  localparam logic [2:0] REG_LIST_EN_ADDR = 3'(4 * REG_LIST_EN);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_BEATS    = 250;
  localparam int HOLD_CYCLES    = 300;          // long receiver hold-off
  localparam int RUSH_BEATS     = 40;           // back-to-back beats during it
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_LIST_EN [4] = '{1, 0, 1, 1};

  typedef struct packed {
    logic permitted;
    logic table_full;
  } verdict_t;

  // set_list >= 0 writes the enable register (block idle) before the row
  typedef struct {
    int          set_list;
    logic [1:0]  op;
    logic [31:0] addr;
    logic [2:0]  pre;
    int          reps;
    bit          typed;
    verdict_t    want;
  } plan_row_t;

  localparam int PLAN_ROWS = 18;
  plan_row_t plan [PLAN_ROWS] = '{
    // list disabled: checks permit, adds still land in the table
    '{ 0, OP_CHECK,  32'hFFFF_FFFF, 3'd7, 1,  1'b1, '{1'b1, 1'b0}},
    '{-1, OP_ADD,    32'h0A00_0000, 3'd1, 1,  1'b0, '{1'b0, 1'b0}},
    // list on: entry added while off must match
    '{ 1, OP_CHECK,  32'h0A0B_0C0D, 3'd0, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_CLEAR,  32'hFFFF_FFFF, 3'd7, 1,  1'b1, '{1'b0, 1'b0}},
    // empty enabled list denies
    '{-1, OP_CHECK,  32'h0000_0000, 3'd0, 1,  1'b1, '{1'b0, 1'b0}},
    // unused op code does nothing
    '{-1, OP_UNUSED, 32'hFFFF_FFFF, 3'd7, 1,  1'b1, '{1'b0, 1'b0}},
    '{-1, OP_ADD,    32'hC0A8_0100, 3'd3, 1,  1'b0, '{1'b0, 1'b0}},
    // prefix past four octets compares the whole address
    '{-1, OP_ADD,    32'h0102_0304, 3'd7, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_ADD,    32'hFFFF_FFFF, 3'd4, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_ADD,    32'hAC10_0000, 3'd2, 13, 1'b0, '{1'b0, 1'b0}},
    // table full: wildcard entry dropped and flagged
    '{-1, OP_ADD,    32'h0000_0000, 3'd0, 1,  1'b1, '{1'b0, 1'b1}},
    '{-1, OP_CHECK,  32'hC0A8_01FF, 3'd0, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_CHECK,  32'hC0A8_02FF, 3'd7, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_CHECK,  32'h0102_0305, 3'd1, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_CHECK,  32'h0102_0304, 3'd2, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_CHECK,  32'hFFFF_FFFF, 3'd3, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_CHECK,  32'hAC10_FFFF, 3'd4, 1,  1'b0, '{1'b0, 1'b0}},
    '{-1, OP_CHECK,  32'h0000_0001, 3'd5, 1,  1'b0, '{1'b0, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [1:0]  operation;
  logic [31:0] address;
  logic [2:0]  prefix_octets;
  logic        out_valid, out_stall;
  logic        permitted, table_full;

  ipv4_prefix_access_check #(.MAX_ENTRIES(ACL_DEPTH)) dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .operation, .address, .prefix_octets,
    .out_valid, .out_stall, .permitted, .table_full
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the access table
  logic [31:0] acl_addr   [ACL_DEPTH];
  logic [2:0]  acl_prefix [ACL_DEPTH];
  int          acl_count   = 0;
  bit          acl_enabled = 1'b0;

  verdict_t    verdict_q [$];     // expected result beats, oldest first
  int          mismatches = 0;
  int          beats_sent = 0;

  // what the driver is offering; the monitor reads these at the accept edge
  bit          cur_typed = 1'b0;
  verdict_t    cur_want  = '0;

  // idle pacing: stretches of calm (no gaps) alternate with random gaps
  int          tx_left = 0, rx_left = 0;
  bit          tx_calm = 1'b0, rx_calm = 1'b0;
  int          rush_left = 0;
  bit          hold_off  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(8, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // applies one beat to the table model, returns the result it should give
  function automatic verdict_t acl_predict(input logic [1:0] op, input logic [31:0] addr,
                                           input logic [2:0] pre);
    verdict_t v;
    int       octets;
    bit       hit;
    v = '0;
    case (op)
      OP_CLEAR: acl_count = 0;
      OP_ADD: begin
        if (acl_count < ACL_DEPTH) begin
          acl_addr[acl_count]   = addr;
          acl_prefix[acl_count] = pre;
          acl_count++;
        end else begin
          v.table_full = 1'b1;
        end
      end
      OP_CHECK: begin
        hit = !acl_enabled;
        for (int i = 0; i < acl_count; i++) begin
          octets = (acl_prefix[i] > PREFIX_OCTETS_MAX) ? PREFIX_OCTETS_MAX
                                                       : int'(acl_prefix[i]);
          // shift by 32 leaves zero on both sides: zero octets match all
          if ((addr >> (32 - 8 * octets)) == (acl_addr[i] >> (32 - 8 * octets)))
            hit = 1'b1;
        end
        v.permitted = hit;
      end
      default: ;
    endcase
    return v;
  endfunction

  // address built mostly from a few common octets so entries collide
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 2) != 0) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 4))
          0: a[8*k +: 8] = 8'h00;
          1: a[8*k +: 8] = 8'h0A;
          2: a[8*k +: 8] = 8'hC0;
          3: a[8*k +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return a;
  endfunction

  // Offer one beat and hold it until taken. Called at a falling edge and
  // returns at one. Valid stays high into the next beat when it has no gap.
  task automatic send_beat(input logic [1:0] op, input logic [31:0] addr,
                           input logic [2:0] pre, input bit typed = 1'b0,
                           input verdict_t want = '0);
    int gap;
    if (rush_left > 0) begin
      gap = 0;
      rush_left--;
    end else begin
      gap = draw_wait(tx_left, tx_calm);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation     = op;
    address       = addr;
    prefix_octets = pre;
    cur_typed     = typed;
    cur_want      = want;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write of the enable register, then a read back of it
  task automatic cfg_write(input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_LIST_EN_ADDR;
    pwdata  = value;
    @(negedge clk) penable = 1'b1;
    @(posedge clk) acl_enabled = value[0];
    @(negedge clk) begin
      penable = 1'b0;
      pwrite  = 1'b0;
    end
    @(negedge clk) penable = 1'b1;
    @(posedge clk) begin
      if (prdata !== 32'(value[0]))
        report_mismatch($sformatf("list enable read back %h, wrote %0d", prdata, value[0]));
    end
    @(negedge clk) begin
      psel    = 1'b0;
      penable = 1'b0;
    end
  endtask

  // one well-formed session: clear, some adds, checks near the entries
  task automatic run_session();
    logic [31:0] kept [$];
    logic [31:0] a;
    int          n_add;
    n_add = ($urandom_range(0, 7) == 0) ? $urandom_range(ACL_DEPTH, ACL_DEPTH + 3)
                                         : $urandom_range(0, 8);
    send_beat(OP_CLEAR, $urandom, 3'($urandom_range(0, 7)));
    repeat (n_add) begin
      a = pick_addr();
      send_beat(OP_ADD, a, ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7)));
      if (kept.size() < ACL_DEPTH) kept.push_back(a);
    end
    repeat ($urandom_range(4, 12)) begin
      if (kept.size() > 0 && $urandom_range(0, 3) != 0) begin
        a = kept[$urandom_range(0, kept.size() - 1)];
        // near miss: one flipped bit may or may not fall inside the prefix
        if ($urandom_range(0, 1) == 1) a[$urandom_range(0, 31)] ^= 1'b1;
      end else begin
        a = pick_addr();
      end
      send_beat(OP_CHECK, a, 3'($urandom_range(0, 7)));
    end
  endtask

  // scoreboard: results are checked first, then the accepted beat is modeled
  always @(posedge clk) begin
    verdict_t want;
    verdict_t model;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (permitted !== want.permitted)
            report_mismatch($sformatf("permitted %b, want %b", permitted, want.permitted));
          if (table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, want %b", table_full, want.table_full));
        end
      end
      if (in_valid && !in_stall) begin
        model = acl_predict(operation, address, prefix_octets);
        verdict_q.push_back(cur_typed ? cur_want : model);
      end
    end
  end

  // receiver: random stall before each result, one long hold-off on request
  initial begin
    int w;
    out_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_off) begin
        hold_off  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        w = draw_wait(rx_left, rx_calm);
        if (w > 0) begin
          out_stall = 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // watchdog: too long without a beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("ipv4_prefix_access_check_tb failed");
    $finish;
  end

  initial begin
    int phase_end;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    operation     = OP_CLEAR;
    address       = '0;
    prefix_octets = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed table
    foreach (plan[r]) begin
      if (plan[r].set_list >= 0) begin
        drain_results();
        cfg_write(32'(plan[r].set_list));
      end
      repeat (plan[r].reps)
        send_beat(plan[r].op, plan[r].addr, plan[r].pre, plan[r].typed, plan[r].want);
    end

    // random phases, one enable setting each
    foreach (PHASE_LIST_EN[ph]) begin
      drain_results();
      cfg_write(32'(PHASE_LIST_EN[ph]));
      if (ph == 0) begin
        // receiver freezes while the sender keeps pushing: back-pressure
        hold_off  = 1'b1;
        rush_left = RUSH_BEATS;
      end
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7)
          run_session();
        else
          send_beat(2'($urandom_range(0, 3)), $urandom, 3'($urandom_range(0, 7)));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", verdict_q.size()));
    if (mismatches == 0)
      $display("ipv4_prefix_access_check_tb passed");
    else
      $display("ipv4_prefix_access_check_tb failed");
    $finish;
  end

endmodule
